// ----- sv/bfg_pkg.sv -----
package bfg_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_RADIUS  = 3;
   localparam int ROW_LIMIT   = 2048;
   localparam int SLOT_COUNT  = 2 * MAX_RADIUS + 1;
   localparam int SLOT_W      = $clog2(SLOT_COUNT + 1);
   localparam int HIST_DEPTH  = SLOT_COUNT;
   localparam int RC_W        = $clog2(HIST_DEPTH + 1);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 11;
   localparam int GEOM_W      = 12;
   localparam int RAD_W       = 2;
   localparam int GAIN_W      = 16;
   localparam int CH_W        = 8;
   localparam int CHANNELS    = 3;
   localparam int PIX_W       = CH_W * CHANNELS;
   localparam int PROD_W      = CH_W + GAIN_W;

   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
   localparam int OUT_DEPTH   = 8;
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [GEOM_W-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [GEOM_W-1:0] RESET_HEIGHT = 12'd480;
   localparam logic [RAD_W-1:0]  RESET_RADIUS = 2'd1;
   localparam logic [GAIN_W-1:0] RESET_GAIN   = 16'd0;

   localparam logic [GAIN_W-1:0] LUMA_R = 16'd19595;
   localparam logic [GAIN_W-1:0] LUMA_G = 16'd38470;
   localparam logic [GAIN_W-1:0] LUMA_B = 16'd7471;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_RADIUS,
      REG_GAIN
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_PASS = 2'd0,
      KIND_GRAY = 2'd1,
      KIND_FILT = 2'd2
   } kind_type;

   typedef struct packed {
      logic [CH_W-1:0] in_red;
      logic [CH_W-1:0] in_green;
      logic [CH_W-1:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] pix_row;
      logic [COL_W-1:0] pix_col;
      logic [CH_W-1:0]  out_red;
      logic [CH_W-1:0]  out_green;
      logic [CH_W-1:0]  out_blue;
      logic [1:0]       pix_kind;
      logic             last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [GEOM_W-1:0] image_width;
      logic [GEOM_W-1:0] image_height;
      logic [RAD_W-1:0]  radius;
      logic [GAIN_W-1:0] gain_q16;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [PIX_W-1:0]  pix;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] centre_slot;
      logic [RAD_W-1:0]  rad;
      logic              emit_filt;
      logic              self_valid;
      kind_type          self_kind;
   } item_type;

   typedef struct packed {
      item_type                          item;
      logic [SLOT_COUNT-1:0][PIX_W-1:0] column;
   } work_type;

endpackage

// ----- sv/box_filter_gain_with_gray_border.sv -----
// RGB box filter with gain and gray border. Pixels of a frame enter in raster
// order, one per clock when the result side keeps up and no rebuild runs; each
// pixel yields zero, one or two result beats (a delayed filtered interior
// pixel, then the pixel itself if it lies on the gray ring or the outer border).
// The rate is set by the line stores, one port per row slot, read once per pixel
// at its column, and by the column-sum pipeline behind them; results pass the
// front register, work queue, back stages and result queue. A register write
// makes the filter rebuild its column sums before it takes the next pixel from
// its internal queue. Write registers only while no pixel is in flight.
module box_filter_gain_with_gray_border import bfg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type            cfg_ff, cfg_in;
   logic               q_push, q_pop, q_empty;
   logic [Q_CNT_W-1:0] q_count;
   work_type           q_in_data, q_out_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[GEOM_W-1:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[GEOM_W-1:0];
            REG_RADIUS:       cfg_in.radius       = csr_wdata[RAD_W-1:0];
            REG_GAIN:         cfg_in.gain_q16     = csr_wdata[GAIN_W-1:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= RESET_WIDTH;
         cfg_ff.image_height <= RESET_HEIGHT;
         cfg_ff.radius       <= RESET_RADIUS;
         cfg_ff.gain_q16     <= RESET_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bfg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   bfg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .empty     (q_empty),
      .count     (q_count),
      .head_data (q_out_data)
   );

   bfg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cfg_written (csr_we),
      .q_empty     (q_empty),
      .q_data      (q_out_data),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- sv/bfg_ram.sv -----
module bfg_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/bfg_queue.sv -----
module bfg_queue import bfg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  work_type           push_data,
   input  logic               pop,
   output logic               empty,
   output logic [Q_CNT_W-1:0] count,
   output work_type           head_data
);

   work_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wp_ff, wp_in;
   logic [Q_PTR_W-1:0]   rp_ff, rp_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   assign empty     = (cnt_ff == '0);
   assign count     = cnt_ff;
   assign head_data = mem_ff[rp_ff];

endmodule

// ----- sv/bfg_front.sv -----
module bfg_front import bfg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_push,
   output logic               req_full,
   input  req_type            req_data,
   input  logic [Q_CNT_W-1:0] q_count,
   output logic               q_push,
   output work_type           q_data
);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [SLOT_W-1:0] m3_ff, m3_in, m5_ff, m5_in, m7_ff, m7_in;
   logic              f1_valid_ff;
   item_type          f1_item_ff, f1_item_in;

   logic [GEOM_W-1:0] w_eff, h_eff;
   logic [GEOM_W-1:0] r_a, c_a, r_b, c_b;
   logic [SLOT_W-1:0] m3_a, m5_a, m7_a, m3_b, m5_b, m7_b;
   logic [RAD_W-1:0]  rad;
   logic [SLOT_W-1:0] slots;
   logic [GEOM_W-1:0] rad_g, span_g;
   logic              outer;
   logic              accept;
   item_type          cur;
   logic [PIX_W-1:0]  rd_data [SLOT_COUNT];

   function automatic logic [SLOT_W-1:0] mod_inc(input logic [SLOT_W-1:0] v,
                                                  input logic [SLOT_W-1:0] m);
      mod_inc = (v == m - 1'b1) ? '0 : v + 1'b1;
   endfunction

   always_comb begin
      w_eff = cfg.image_width;
      if (w_eff == '0) begin
         w_eff = GEOM_W'(1);
      end else if (w_eff > GEOM_W'(MAX_WIDTH)) begin
         w_eff = GEOM_W'(MAX_WIDTH);
      end
      h_eff = cfg.image_height;
      if (h_eff == '0) begin
         h_eff = GEOM_W'(1);
      end else if (h_eff > GEOM_W'(ROW_LIMIT)) begin
         h_eff = GEOM_W'(ROW_LIMIT);
      end
      rad    = cfg.radius;
      slots  = {rad, 1'b1};
      rad_g  = GEOM_W'(rad);
      span_g = GEOM_W'(slots);

      c_a  = GEOM_W'(col_ff);
      r_a  = GEOM_W'(row_ff);
      m3_a = m3_ff;
      m5_a = m5_ff;
      m7_a = m7_ff;
      if (c_a >= w_eff) begin
         c_a  = '0;
         r_a  = r_a + 1'b1;
         m3_a = mod_inc(m3_a, SLOT_W'(3));
         m5_a = mod_inc(m5_a, SLOT_W'(5));
         m7_a = mod_inc(m7_a, SLOT_W'(7));
      end
      if (r_a >= h_eff) begin
         r_a  = '0;
         m3_a = '0;
         m5_a = '0;
         m7_a = '0;
      end

      cur.row = r_a[ROW_W-1:0];
      cur.col = c_a[COL_W-1:0];
      cur.pix = {req_data.in_blue, req_data.in_green, req_data.in_red};
      cur.rad = rad;
      case (rad)
         2'd0:    cur.slot = '0;
         2'd1:    cur.slot = m3_a;
         2'd2:    cur.slot = m5_a;
         default: cur.slot = m7_a;
      endcase
      cur.centre_slot = cur.slot - SLOT_W'(rad);
      if (cur.slot < SLOT_W'(rad)) begin
         cur.centre_slot = cur.centre_slot + slots;
      end
      cur.emit_filt = (r_a >= span_g) && (c_a >= span_g);
      outer = (r_a < rad_g) || (r_a + rad_g >= h_eff)
           || (c_a < rad_g) || (c_a + rad_g >= w_eff);
      cur.self_valid = outer || (r_a == rad_g) || (c_a == rad_g);
      cur.self_kind  = outer ? KIND_PASS : KIND_GRAY;

      c_b  = c_a + 1'b1;
      r_b  = r_a;
      m3_b = m3_a;
      m5_b = m5_a;
      m7_b = m7_a;
      if (c_b >= w_eff) begin
         c_b  = '0;
         r_b  = r_a + 1'b1;
         m3_b = mod_inc(m3_a, SLOT_W'(3));
         m5_b = mod_inc(m5_a, SLOT_W'(5));
         m7_b = mod_inc(m7_a, SLOT_W'(7));
         if (r_b >= h_eff) begin
            r_b  = '0;
            m3_b = '0;
            m5_b = '0;
            m7_b = '0;
         end
      end

      req_full = ((Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(f1_valid_ff))
              >= (Q_CNT_W + 1)'(Q_DEPTH);
      accept   = req_push && !req_full;

      row_in     = accept ? r_b[ROW_W-1:0] : row_ff;
      col_in     = accept ? c_b[COL_W-1:0] : col_ff;
      m3_in      = accept ? m3_b : m3_ff;
      m5_in      = accept ? m5_b : m5_ff;
      m7_in      = accept ? m7_b : m7_ff;
      f1_item_in = accept ? cur : f1_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         m3_ff       <= '0;
         m5_ff       <= '0;
         m7_ff       <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         m3_ff       <= m3_in;
         m5_ff       <= m5_in;
         m7_ff       <= m7_in;
         f1_valid_ff <= accept;
      end
      f1_item_ff <= f1_item_in;
   end

   for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_line
      bfg_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (accept && (cur.slot == SLOT_W'(s))),
         .wr_addr (cur.col),
         .wr_data (cur.pix),
         .rd_en   (accept),
         .rd_addr (cur.col),
         .rd_data (rd_data[s])
      );
   end

   always_comb begin
      q_push      = f1_valid_ff;
      q_data.item = f1_item_ff;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         q_data.column[s] = (f1_item_ff.slot == SLOT_W'(s)) ? f1_item_ff.pix : rd_data[s];
      end
   end

endmodule

// ----- sv/bfg_back.sv -----
module bfg_back import bfg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     cfg_written,
   input  logic     q_empty,
   input  work_type q_data,
   output logic     q_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   logic [RC_W-1:0]                    rc_cnt_ff, rc_cnt_in;
   logic                               rc_active;
   logic [SLOT_W-1:0]                  rc_idx;

   logic                               b1_valid_ff, b1_rc_ff;
   logic [SLOT_W-1:0]                  b1_idx_ff;
   item_type                           b1_item_ff;
   logic [SLOT_COUNT-1:0][PIX_W-1:0]  b1_col_ff, col_sel;
   logic [CH_W-1:0]                    b1_tap_ff [SLOT_COUNT][CHANNELS];
   logic [CH_W-1:0]                    tap_in [SLOT_COUNT][CHANNELS];
   logic [PROD_W-1:0]                  prod [SLOT_COUNT][CHANNELS];
   logic [PROD_W-1:0]                  b1_lum_ff [CHANNELS];
   logic [PROD_W-1:0]                  lum_in [CHANNELS];
   logic [SLOT_W-1:0]                  slots;

   logic [CH_W-1:0]                    colsum [CHANNELS];
   logic [PROD_W-1:0]                  lum_sum;
   logic [CH_W-1:0]                    sum_hist_ff [HIST_DEPTH][CHANNELS];
   logic [CH_W-1:0]                    sum_hist_in [HIST_DEPTH][CHANNELS];
   logic [SLOT_COUNT-1:0][PIX_W-1:0]  raw_hist_ff [HIST_DEPTH];
   logic [SLOT_COUNT-1:0][PIX_W-1:0]  raw_hist_in [HIST_DEPTH];
   logic                               b2_valid_ff;
   item_type                           b2_item_ff;
   logic [CH_W-1:0]                    b2_luma_ff;

   logic [PIX_W-1:0]                   centre;
   logic [CH_W-1:0]                    win [CHANNELS];
   rsp_type                            e_filt, e_self, e0, e1;
   logic                               push0, push1, pop_acc;

   rsp_type                            out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]               out_wp_ff, out_wp_in, out_rp_ff, out_rp_in;
   logic [OUT_CNT_W-1:0]               out_cnt_ff, out_cnt_in;
   logic [OUT_CNT_W:0]                 need;

   always_comb begin
      rc_active = (rc_cnt_ff != '0);
      rc_idx    = SLOT_W'(rc_cnt_ff - 1'b1);
      if (cfg_written) begin
         rc_cnt_in = RC_W'(HIST_DEPTH);
      end else if (rc_active) begin
         rc_cnt_in = rc_cnt_ff - 1'b1;
      end else begin
         rc_cnt_in = rc_cnt_ff;
      end

      need = (OUT_CNT_W + 1)'(out_cnt_ff) + (OUT_CNT_W + 1)'({b1_valid_ff, 1'b0})
           + (OUT_CNT_W + 1)'({b2_valid_ff, 1'b0}) + (OUT_CNT_W + 1)'(2);
      q_pop = !rc_active && !cfg_written && !q_empty
           && (need <= (OUT_CNT_W + 1)'(OUT_DEPTH));

      slots   = {cfg.radius, 1'b1};
      col_sel = rc_active ? raw_hist_ff[rc_idx] : q_data.column;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            prod[s][ch]   = PROD_W'(col_sel[s][CH_W*ch +: CH_W]) * PROD_W'(cfg.gain_q16);
            tap_in[s][ch] = (SLOT_W'(s) < slots) ? prod[s][ch][PROD_W-1 -: CH_W] : '0;
         end
      end
      lum_in[0] = PROD_W'(q_data.item.pix[CH_W-1:0]) * PROD_W'(LUMA_R);
      lum_in[1] = PROD_W'(q_data.item.pix[2*CH_W-1:CH_W]) * PROD_W'(LUMA_G);
      lum_in[2] = PROD_W'(q_data.item.pix[3*CH_W-1:2*CH_W]) * PROD_W'(LUMA_B);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_cnt_ff   <= '0;
         b1_valid_ff <= 1'b0;
         b1_rc_ff    <= 1'b0;
      end else begin
         rc_cnt_ff   <= rc_cnt_in;
         b1_valid_ff <= q_pop;
         b1_rc_ff    <= rc_active;
      end
      b1_idx_ff  <= rc_idx;
      b1_item_ff <= q_data.item;
      b1_col_ff  <= col_sel;
      b1_tap_ff  <= tap_in;
      b1_lum_ff  <= lum_in;
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         colsum[ch] = '0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            colsum[ch] = colsum[ch] + b1_tap_ff[s][ch];
         end
      end
      lum_sum     = b1_lum_ff[0] + b1_lum_ff[1] + b1_lum_ff[2];
      sum_hist_in = sum_hist_ff;
      raw_hist_in = raw_hist_ff;
      if (b1_valid_ff) begin
         for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            sum_hist_in[k] = sum_hist_ff[k-1];
            raw_hist_in[k] = raw_hist_ff[k-1];
         end
         sum_hist_in[0] = colsum;
         raw_hist_in[0] = b1_col_ff;
      end else if (b1_rc_ff) begin
         sum_hist_in[b1_idx_ff] = colsum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= b1_valid_ff;
      end
      sum_hist_ff <= sum_hist_in;
      raw_hist_ff <= raw_hist_in;
      b2_item_ff  <= b1_item_ff;
      b2_luma_ff  <= lum_sum[PROD_W-1 -: CH_W];
   end

   always_comb begin
      centre = raw_hist_ff[SLOT_W'(b2_item_ff.rad)][b2_item_ff.centre_slot];
      for (int ch = 0; ch < CHANNELS; ch++) begin
         win[ch] = centre[CH_W*ch +: CH_W];
         for (int k = 0; k < HIST_DEPTH; k++) begin
            if (SLOT_W'(k) <= {b2_item_ff.rad, 1'b0}) begin
               win[ch] = win[ch] + sum_hist_ff[k][ch];
            end
         end
      end

      e_filt.pix_row     = b2_item_ff.row - ROW_W'(b2_item_ff.rad);
      e_filt.pix_col     = b2_item_ff.col - COL_W'(b2_item_ff.rad);
      e_filt.out_red     = win[0];
      e_filt.out_green   = win[1];
      e_filt.out_blue    = win[2];
      e_filt.pix_kind    = KIND_FILT;
      e_filt.last_of_run = 1'b0;

      e_self.pix_row     = b2_item_ff.row;
      e_self.pix_col     = b2_item_ff.col;
      e_self.pix_kind    = b2_item_ff.self_kind;
      e_self.last_of_run = 1'b1;
      if (b2_item_ff.self_kind == KIND_GRAY) begin
         e_self.out_red   = b2_luma_ff;
         e_self.out_green = b2_luma_ff;
         e_self.out_blue  = b2_luma_ff;
      end else begin
         e_self.out_red   = b2_item_ff.pix[CH_W-1:0];
         e_self.out_green = b2_item_ff.pix[2*CH_W-1:CH_W];
         e_self.out_blue  = b2_item_ff.pix[3*CH_W-1:2*CH_W];
      end

      push0 = b2_valid_ff && (b2_item_ff.emit_filt || b2_item_ff.self_valid);
      push1 = b2_valid_ff && b2_item_ff.emit_filt && b2_item_ff.self_valid;
      e0             = b2_item_ff.emit_filt ? e_filt : e_self;
      e0.last_of_run = !push1;
      e1             = e_self;

      rsp_empty  = (out_cnt_ff == '0);
      rsp_data   = out_mem_ff[out_rp_ff];
      pop_acc    = rsp_pop && !rsp_empty;
      out_wp_in  = out_wp_ff + OUT_PTR_W'(push0) + OUT_PTR_W'(push1);
      out_rp_in  = out_rp_ff + OUT_PTR_W'(pop_acc);
      out_cnt_in = out_cnt_ff + OUT_CNT_W'(push0) + OUT_CNT_W'(push1)
                 - OUT_CNT_W'(pop_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wp_ff  <= '0;
         out_rp_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         out_wp_ff  <= out_wp_in;
         out_rp_ff  <= out_rp_in;
         out_cnt_ff <= out_cnt_in;
      end
      if (push0) begin
         out_mem_ff[out_wp_ff] <= e0;
      end
      if (push1) begin
         out_mem_ff[out_wp_ff + 1'b1] <= e1;
      end
   end

endmodule
